// ----- hdl/ccsb_pkg.sv -----
// ----------------------------------------------------------------------------
// ccsb_pkg
// Shared types and character constants for the C comment and string blanker.
// ----------------------------------------------------------------------------
package ccsb_pkg;

  // Character codes that steer the scanner.
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Output queue geometry. The depth must stay a power of two so that the
  // pointers wrap on their own.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Scanner mode.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_LINE   = 3'd1,
    MODE_BLOCK  = 3'd2,
    MODE_STR    = 3'd3,
    MODE_CHR    = 3'd4
  } mode_t;

  // One output byte with its end-of-text flag.
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } out_item_t;

  // What one input byte produces: zero, one or two output bytes.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  item0;
    out_item_t  item1;
  } step_result_t;

endpackage

// ----- hdl/ccsb_scanner.sv -----
// ----------------------------------------------------------------------------
// ccsb_scanner
// Scan state and per-byte decode: turns one source byte into up to two
// cleaned bytes and updates the mode on each transfer.
// ----------------------------------------------------------------------------
module ccsb_scanner (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            text_byte,
  input  logic                  is_final,
  output ccsb_pkg::step_result_t result
);
  import ccsb_pkg::*;

  mode_t mode, mode_next;
  logic  slash_held, slash_held_next;
  logic  star_seen, star_seen_next;
  logic  escape_open, escape_open_next;

  logic [7:0] quote;
  logic [7:0] blank_or_nl;
  logic       norm_emit;
  mode_t      norm_mode;
  logic       norm_esc;
  logic [1:0] count;
  logic [7:0] byte0, byte1;

  // Helpers shared by several modes.
  assign quote       = (mode == MODE_STR) ? CH_DQUOTE : CH_SQUOTE;
  assign blank_or_nl = (text_byte == CH_NL) ? CH_NL : CH_SPACE;

  // Handling of a byte as plain text, also used for the byte after a released slash.
  always_comb begin
    norm_emit = !(text_byte == CH_SLASH && !is_final);
    norm_mode = mode;
    norm_esc  = escape_open;
    if (text_byte == CH_DQUOTE) begin
      norm_mode = MODE_STR;
      norm_esc  = 1'b0;
    end else if (text_byte == CH_SQUOTE) begin
      norm_mode = MODE_CHR;
      norm_esc  = 1'b0;
    end
  end

  // Mode decode and the bytes it produces.
  always_comb begin
    mode_next        = mode;
    slash_held_next  = slash_held;
    star_seen_next   = star_seen;
    escape_open_next = escape_open;
    count            = 2'd0;
    byte0            = CH_SPACE;
    byte1            = CH_SPACE;
    unique case (mode)
      MODE_LINE: begin
        count = 2'd1;
        byte0 = blank_or_nl;
        if (text_byte == CH_NL) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        count = 2'd1;
        if (star_seen && text_byte == CH_SLASH) begin
          star_seen_next = 1'b0;
          mode_next      = MODE_NORMAL;
          byte0          = CH_SPACE;
        end else begin
          star_seen_next = (text_byte == CH_STAR);
          byte0          = blank_or_nl;
        end
      end
      MODE_STR, MODE_CHR: begin
        count = 2'd1;
        priority if (escape_open) begin
          escape_open_next = 1'b0;
          byte0            = blank_or_nl;
        end else if (text_byte == CH_BSLASH) begin
          escape_open_next = 1'b1;
          byte0            = CH_SPACE;
        end else if (text_byte == quote) begin
          mode_next = MODE_NORMAL;
          byte0     = quote;
        end else begin
          byte0 = blank_or_nl;
        end
      end
      default: begin
        // Normal text; the unused mode codes fall here as well.
        if (slash_held) begin
          slash_held_next = 1'b0;
          if (text_byte == CH_SLASH) begin
            mode_next = MODE_LINE;
            count     = 2'd2;
          end else if (text_byte == CH_STAR) begin
            mode_next      = MODE_BLOCK;
            star_seen_next = 1'b0;
            count          = 2'd2;
          end else begin
            // The held slash was no comment: release it, then the new byte unless it is held.
            byte0            = CH_SLASH;
            byte1            = text_byte;
            count            = norm_emit ? 2'd2 : 2'd1;
            slash_held_next  = !norm_emit;
            mode_next        = norm_mode;
            escape_open_next = norm_esc;
          end
        end else begin
          byte0            = text_byte;
          count            = norm_emit ? 2'd1 : 2'd0;
          slash_held_next  = !norm_emit;
          mode_next        = norm_mode;
          escape_open_next = norm_esc;
        end
      end
    endcase
    // The last byte of a text returns everything to the start state.
    if (is_final) begin
      mode_next        = MODE_NORMAL;
      slash_held_next  = 1'b0;
      star_seen_next   = 1'b0;
      escape_open_next = 1'b0;
    end
  end

  // Result bundle; the end flag goes on the last byte produced.
  always_comb begin
    result.count      = count;
    result.item0.data = byte0;
    result.item0.last = is_final && (count == 2'd1);
    result.item1.data = byte1;
    result.item1.last = is_final && (count == 2'd2);
  end

  // State registers, updated on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      slash_held  <= 1'b0;
      star_seen   <= 1'b0;
      escape_open <= 1'b0;
    end else if (step) begin
      mode        <= mode_next;
      slash_held  <= slash_held_next;
      star_seen   <= star_seen_next;
      escape_open <= escape_open_next;
    end
  end

`ifndef SYNTH
  // A pending slash only exists in normal text.
  a_slash_mode: assert property (@(posedge clk) disable iff (rst)
    slash_held |-> (mode == MODE_NORMAL))
    else $error("slash held outside normal text");

  // A seen star only exists inside a block comment.
  a_star_mode: assert property (@(posedge clk) disable iff (rst)
    star_seen |-> (mode == MODE_BLOCK))
    else $error("star flag outside block comment");

  // An open escape only exists inside a literal.
  a_esc_mode: assert property (@(posedge clk) disable iff (rst)
    escape_open |-> (mode == MODE_STR || mode == MODE_CHR))
    else $error("escape open outside literal");

  // The last byte of a text leaves the scanner in its start state.
  a_final_reset: assert property (@(posedge clk) disable iff (rst)
    (step && is_final) |=> (mode == MODE_NORMAL && !slash_held && !escape_open))
    else $error("state not cleared after final byte");
`endif

endmodule

// ----- hdl/ccsb_outq.sv -----
// ----------------------------------------------------------------------------
// ccsb_outq
// Small output queue: takes up to two bytes per cycle and gives one per
// transfer on the output stream.
// ----------------------------------------------------------------------------
module ccsb_outq (
  input  logic                   clk,
  input  logic                   rst,
  input  ccsb_pkg::step_result_t push,
  output logic                   has_room,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,   // [7:0] clean_byte
  output logic                   m_tlast    // end_of_text
);
  import ccsb_pkg::*;

  out_item_t           entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count, count_next;
  logic                pop;
  logic [QPTR_W-1:0]   wr_ptr_1;

  // Room for a full two-byte step, whatever the output side does.
  assign has_room = (count <= QCNT_W'(QDEPTH - 2));

  assign m_tvalid = (count != '0);
  assign m_tdata  = entries[rd_ptr].data;
  assign m_tlast  = entries[rd_ptr].last;
  assign pop      = m_tvalid && m_tready;
  assign wr_ptr_1 = wr_ptr + QPTR_W'(1);

  // Occupancy after this cycle's writes and read.
  always_comb begin
    count_next = count + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.item0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_1] <= push.item1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

`ifndef SYNTH
  // Writes only arrive when there is room for two bytes.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> has_room)
    else $error("queue written without room");

  // The queue never holds more than its depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue overflow");

  // Read and write pointers stay apart by exactly the occupancy while the queue is not full.
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count < QCNT_W'(QDEPTH)) |-> (QPTR_W'(wr_ptr - rd_ptr) == count[QPTR_W-1:0]))
    else $error("queue pointers inconsistent with count");
`endif

endmodule

// ----- hdl/c_comment_string_blanker.sv -----
// Output: a byte shows on m_tdata in the cycle after its transfer when the queue is empty;
//   a slash in normal text is held until the next byte (or is released at once if final).
// Throughput: one input byte per cycle while s_tready is high; the output port moves one
//   byte per cycle while m_tready is high; a four-entry queue absorbs two-byte steps.
// Reset: synchronous, active high; clears the scan mode, all flags and the output queue.
// ----------------------------------------------------------------------------
// c_comment_string_blanker
// Replaces C comments and the insides of string and character literals with
// spaces, keeping newlines and quote delimiters; it takes one source byte per transfer.
// ----------------------------------------------------------------------------
module c_comment_string_blanker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // is_final
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] clean_byte
  output logic       m_tlast    // end_of_text
);
  import ccsb_pkg::*;

  step_result_t result, push;
  logic         step;
  logic         has_room;

  assign s_tready = has_room;
  assign step     = s_tvalid && s_tready;

  // Only a real transfer writes into the queue.
  always_comb begin
    push = result;
    if (!step) begin
      push.count = 2'd0;
    end
  end

  ccsb_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .text_byte (s_tdata),
    .is_final  (s_tlast),
    .result    (result)
  );

  ccsb_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .has_room (has_room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
